[hw/rtl/phm_pkg.sv]
package phm_pkg;

   localparam int CELL_W      = 20;
   localparam int VALUE_W     = 16;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VALUE_MIN     = 2'd0,
      CSR_VALUE_MAX     = 2'd1,
      CSR_NO_DATA_VALUE = 2'd2
   } csr_index_type;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN_RESET     = 16'sd0;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX_RESET     = 16'sd255;
   localparam logic signed [VALUE_W-1:0] NO_DATA_VALUE_RESET = -16'sd1;

endpackage

[hw/rtl/phm_ram.sv]
module phm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

[hw/rtl/per_cell_mode_histogram.sv]
// an item that closes no cell is accepted, then its bin is read and then written
// each cell flush adds a sweep over the bin memory plus a load of the result register;
// an item holds the block until its work is done
// the block takes no new item until it is through with the last one
// reset: after reset the bin memory is cleared with req_ready low
module per_cell_mode_histogram #(
   parameter int BIN_COUNT       = 256,
   parameter int CELL_INDEX_BITS = 20,
   parameter int COUNT_BITS      = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [phm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [phm_pkg::VALUE_W-1:0]           csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [phm_pkg::CELL_W-1:0]            req_cell_index,
   input  logic signed [phm_pkg::VALUE_W-1:0]    req_sample_value,
   input  logic                                  req_last_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [phm_pkg::CELL_W-1:0]            rsp_out_cell,
   output logic signed [phm_pkg::VALUE_W-1:0]    rsp_mode_value,
   output logic                                  rsp_is_no_data,
   output logic                                  rsp_end_of_run
);
   import phm_pkg::*;

   localparam int AW = $clog2(BIN_COUNT);
   localparam int SW = AW + 1;
   localparam int CW = (CELL_INDEX_BITS < CELL_W) ? CELL_INDEX_BITS : CELL_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
   localparam logic [SW-1:0]         SCAN_END   = SW'(BIN_COUNT);
   localparam logic [SW-1:0]         CLEAR_LAST = SW'(BIN_COUNT - 1);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_COUNT_RD = 6'b000100,
      ST_COUNT_WR = 6'b001000,
      ST_SCAN     = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic signed [VALUE_W-1:0] vmin_ff, vmin_in;
   logic signed [VALUE_W-1:0] vmax_ff, vmax_in;
   logic signed [VALUE_W-1:0] nodata_ff, nodata_in;

   logic                      open_ff, open_in;
   logic [CW-1:0]             open_cell_ff, open_cell_in;
   logic [CW-1:0]             cell_ff, cell_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      last_ff, last_in;
   logic                      flush_last_ff, flush_last_in;

   logic [SW-1:0]             scan_ff, scan_in;
   logic                      pv_ff, pv_in;
   logic [AW-1:0]             pa_ff, pa_in;
   logic [COUNT_BITS-1:0]     best_cnt_ff, best_cnt_in;
   logic [AW-1:0]             best_idx_ff, best_idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]         rsp_cell_ff, rsp_cell_in;
   logic signed [VALUE_W-1:0] rsp_mode_ff, rsp_mode_in;
   logic                      rsp_nodata_ff, rsp_nodata_in;
   logic                      rsp_end_ff, rsp_end_in;

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [COUNT_BITS-1:0]     ram_wdata;
   logic [AW-1:0]             ram_raddr;
   logic [COUNT_BITS-1:0]     ram_rdata;

   logic signed [VALUE_W:0]   diff;
   logic signed [VALUE_W+1:0] range_s;
   logic                      in_window;
   logic                      bin_in_window;
   logic [CW-1:0]             req_cell;

   phm_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   assign req_cell = req_cell_index[CW-1:0];
   assign diff     = {val_ff[VALUE_W-1], val_ff} - {vmin_ff[VALUE_W-1], vmin_ff};
   assign range_s  = {{2{vmax_ff[VALUE_W-1]}}, vmax_ff}
                   - {{2{vmin_ff[VALUE_W-1]}}, vmin_ff} + 18'sd1;
   assign in_window = !diff[VALUE_W] && (val_ff <= vmax_ff)
                    && ($unsigned(diff) < (VALUE_W+1)'(BIN_COUNT));
   assign bin_in_window = $signed({{(VALUE_W+2-AW){1'b0}}, pa_ff}) < range_s;

   always_comb begin
      state_in      = state_ff;
      vmin_in       = vmin_ff;
      vmax_in       = vmax_ff;
      nodata_in     = nodata_ff;
      open_in       = open_ff;
      open_cell_in  = open_cell_ff;
      cell_in       = cell_ff;
      val_in        = val_ff;
      last_in       = last_ff;
      flush_last_in = flush_last_ff;
      scan_in       = scan_ff;
      pv_in         = 1'b0;
      pa_in         = pa_ff;
      best_cnt_in   = best_cnt_ff;
      best_idx_in   = best_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_mode_in   = rsp_mode_ff;
      rsp_nodata_in = rsp_nodata_ff;
      rsp_end_in    = rsp_end_ff;
      ram_we        = 1'b0;
      ram_waddr     = pa_ff;
      ram_wdata     = '0;
      ram_raddr     = scan_ff[AW-1:0];

      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_VALUE_MIN:     vmin_in   = csr_write_data;
            CSR_VALUE_MAX:     vmax_in   = csr_write_data;
            CSR_NO_DATA_VALUE: nodata_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[AW-1:0];
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cell_in = req_cell;
               val_in  = req_sample_value;
               last_in = req_last_item;
               if (open_ff && (req_cell > open_cell_ff)) begin
                  flush_last_in = 1'b0;
                  scan_in       = '0;
                  best_cnt_in   = '0;
                  best_idx_in   = '0;
                  state_in      = ST_SCAN;
               end else begin
                  if (!open_ff) begin
                     open_in      = 1'b1;
                     open_cell_in = req_cell;
                  end
                  state_in = ST_COUNT_RD;
               end
            end
         end
         ST_COUNT_RD: begin
            ram_raddr = diff[AW-1:0];
            state_in  = ST_COUNT_WR;
         end
         ST_COUNT_WR: begin
            ram_we    = in_window;
            ram_waddr = diff[AW-1:0];
            ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + 1'b1;
            if (last_ff) begin
               flush_last_in = 1'b1;
               scan_in       = '0;
               best_cnt_in   = '0;
               best_idx_in   = '0;
               state_in      = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            ram_raddr = scan_ff[AW-1:0];
            pv_in     = (scan_ff != SCAN_END);
            pa_in     = scan_ff[AW-1:0];
            if (scan_ff != SCAN_END) begin
               scan_in = scan_ff + 1'b1;
            end
            if (pv_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pa_ff;
               if (bin_in_window && (ram_rdata > best_cnt_ff)) begin
                  best_cnt_in = ram_rdata;
                  best_idx_in = pa_ff;
               end
            end
            if ((scan_ff == SCAN_END) && !pv_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = CELL_W'(open_cell_ff);
               rsp_nodata_in = (best_cnt_ff == '0);
               rsp_mode_in   = (best_cnt_ff == '0) ? nodata_ff
                             : vmin_ff + $signed(VALUE_W'(best_idx_ff));
               rsp_end_in    = flush_last_ff;
               if (flush_last_ff) begin
                  open_in      = 1'b0;
                  open_cell_in = '0;
                  state_in     = ST_IDLE;
               end else begin
                  open_cell_in = cell_ff;
                  state_in     = ST_COUNT_RD;
               end
            end
         end
         default: begin
            scan_in  = '0;
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         pv_ff        <= 1'b0;
         open_ff      <= 1'b0;
         open_cell_ff <= '0;
         rsp_valid_ff <= 1'b0;
         vmin_ff      <= VALUE_MIN_RESET;
         vmax_ff      <= VALUE_MAX_RESET;
         nodata_ff    <= NO_DATA_VALUE_RESET;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pv_ff        <= pv_in;
         open_ff      <= open_in;
         open_cell_ff <= open_cell_in;
         rsp_valid_ff <= rsp_valid_in;
         vmin_ff      <= vmin_in;
         vmax_ff      <= vmax_in;
         nodata_ff    <= nodata_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff       <= cell_in;
      val_ff        <= val_in;
      last_ff       <= last_in;
      flush_last_ff <= flush_last_in;
      pa_ff         <= pa_in;
      best_cnt_ff   <= best_cnt_in;
      best_idx_ff   <= best_idx_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_nodata_ff <= rsp_nodata_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_cell   = rsp_cell_ff;
   assign rsp_mode_value = rsp_mode_ff;
   assign rsp_is_no_data = rsp_nodata_ff;
   assign rsp_end_of_run = rsp_end_ff;

endmodule

[hw/rtl/phm_checker.sv]
module phm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [phm_pkg::CELL_W-1:0]         rsp_out_cell,
   input logic signed [phm_pkg::VALUE_W-1:0] rsp_mode_value,
   input logic                               rsp_is_no_data,
   input logic                               rsp_end_of_run
);
   import phm_pkg::*;

   // reset starts the bin clear with nothing pending
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("reset did not leave the block busy and empty");

   // one item in flight: no new transaction and no new result right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("block took or answered too early after an input transaction");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_cell)
         && $stable(rsp_mode_value) && $stable(rsp_is_no_data) && $stable(rsp_end_of_run))
      else $error("stalled result changed");

endmodule

bind per_cell_mode_histogram phm_checker u_phm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_cell   (rsp_out_cell),
   .rsp_mode_value (rsp_mode_value),
   .rsp_is_no_data (rsp_is_no_data),
   .rsp_end_of_run (rsp_end_of_run)
);
